// File: hw/rtl/oasd_pkg.sv
// Shared types, register map and constants for the obstacle-avoidance steering block.
// No dependencies.
`timescale 1ns / 1ps

package oasd_pkg;

  localparam int ADDR_W = 5;

  // register index, byte address is 4 * index
  localparam logic [2:0] REG_STOP_MM       = 3'd0;
  localparam logic [2:0] REG_STEERING_GAIN = 3'd1;
  localparam logic [2:0] REG_MAX_STEERING  = 3'd2;
  localparam logic [2:0] REG_CLEAR_LIMIT   = 3'd3;
  localparam logic [2:0] REG_SRV_MID       = 3'd4;
  localparam logic [2:0] REG_SRV_LO        = 3'd5;
  localparam logic [2:0] REG_SRV_HI        = 3'd6;
  localparam logic [2:0] REG_AVOID_MOTOR   = 3'd7;

  // decision codes
  localparam logic [1:0] DEC_TOO_CLOSE   = 2'd0;
  localparam logic [1:0] DEC_AVOID_START = 2'd1;
  localparam logic [1:0] DEC_AVOIDING    = 2'd2;
  localparam logic [1:0] DEC_CLEAR       = 2'd3;

  // negate steering before servo mapping
  localparam logic STEER_INVERT = 1'b0;

  typedef struct packed {
    logic [15:0] stop_mm;
    logic [15:0] steering_gain;
    logic [14:0] max_steering;
    logic [9:0]  clear_limit;
    logic [15:0] srv_mid;
    logic [15:0] srv_lo;
    logic [15:0] srv_hi;
    logic [15:0] avoid_motor_command;
  } cfg_t;

endpackage

// File: hw/rtl/oasd_cfg.sv
// APB-style configuration registers for the steering decision block.
// Depends on oasd_pkg.
`timescale 1ns / 1ps

module oasd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [oasd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output oasd_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_mm             <= 16'd200;
      cfg.steering_gain       <= 16'd1678;
      cfg.max_steering        <= 15'd16384;
      cfg.clear_limit         <= 10'd20;
      cfg.srv_mid             <= 16'd37356;
      cfg.srv_lo              <= 16'd0;
      cfg.srv_hi              <= 16'd65535;
      cfg.avoid_motor_command <= 16'd60;
    end else if (wr_en) begin
      unique case (idx)
        oasd_pkg::REG_STOP_MM:       cfg.stop_mm             <= pwdata[15:0];
        oasd_pkg::REG_STEERING_GAIN: cfg.steering_gain       <= pwdata[15:0];
        oasd_pkg::REG_MAX_STEERING:  cfg.max_steering        <= pwdata[14:0];
        oasd_pkg::REG_CLEAR_LIMIT:   cfg.clear_limit         <= pwdata[9:0];
        oasd_pkg::REG_SRV_MID:       cfg.srv_mid             <= pwdata[15:0];
        oasd_pkg::REG_SRV_LO:        cfg.srv_lo              <= pwdata[15:0];
        oasd_pkg::REG_SRV_HI:        cfg.srv_hi              <= pwdata[15:0];
        oasd_pkg::REG_AVOID_MOTOR:   cfg.avoid_motor_command <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (idx)
      oasd_pkg::REG_STOP_MM:       prdata = {16'd0, cfg.stop_mm};
      oasd_pkg::REG_STEERING_GAIN: prdata = {16'd0, cfg.steering_gain};
      oasd_pkg::REG_MAX_STEERING:  prdata = {17'd0, cfg.max_steering};
      oasd_pkg::REG_CLEAR_LIMIT:   prdata = {22'd0, cfg.clear_limit};
      oasd_pkg::REG_SRV_MID:       prdata = {16'd0, cfg.srv_mid};
      oasd_pkg::REG_SRV_LO:        prdata = {16'd0, cfg.srv_lo};
      oasd_pkg::REG_SRV_HI:        prdata = {16'd0, cfg.srv_hi};
      oasd_pkg::REG_AVOID_MOTOR:   prdata = {16'd0, cfg.avoid_motor_command};
      default: prdata = 32'd0;
    endcase
  end

endmodule

// File: hw/rtl/oasd_mul.sv
// Shared signed 18x18 multiplier with registered product.
// No dependencies beyond the timescale.
`timescale 1ns / 1ps

module oasd_mul (
  input  logic               clk,
  input  logic signed [17:0] op_a,
  input  logic signed [17:0] op_b,
  output logic signed [35:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// File: hw/rtl/oasd_seq.sv
// Sequencer: tick decision, state update, rounding and clamping around the shared multiplier.
// Depends on oasd_pkg; drives oasd_mul operands.
`timescale 1ns / 1ps

module oasd_seq (
  input  logic               clk,
  input  logic               rst,
  input  oasd_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] gap_dir,
  input  logic [15:0]        nearest_distance,
  input  logic               obstacle_present,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        servo_position,
  output logic [15:0]        motor_command,
  output logic [1:0]         decision,
  output logic               avoiding_now,
  output logic signed [17:0] op_a,
  output logic signed [17:0] op_b,
  input  logic signed [35:0] prod
);

  typedef enum logic [2:0] {S_IDLE, S_MUL1, S_STEER, S_MUL2, S_SERVO} state_t;

  state_t      state;
  logic        avoid_mode;
  logic [9:0]  clear_ticks;
  logic        steer_en;
  logic [15:0] motor_r;
  logic [1:0]  dec_r;
  logic signed [16:0] range_r;

  logic        accept;
  logic [9:0]  ticks_inc;
  logic [1:0]  dec_next;
  logic        steer_next;
  logic        avoid_next;
  logic [9:0]  ticks_next;
  logic signed [16:0] r1, r2, range_next;

  // steering stage
  logic        p_neg;
  logic [35:0] p_mag, p_sum;
  logic [27:0] s_q;
  logic [14:0] s_mag;
  logic signed [15:0] steer;

  // servo stage
  logic        v_neg;
  logic [35:0] v_mag, v_sum;
  logic [20:0] v_q;
  logic signed [18:0] pos_raw, pos, lo19, hi19;
  logic        out_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign ticks_inc = clear_ticks + 10'd1;
  assign out_free  = ~out_valid | out_ready;

  always_comb begin
    dec_next   = oasd_pkg::DEC_CLEAR;
    steer_next = 1'b0;
    avoid_next = avoid_mode;
    ticks_next = clear_ticks;
    if (nearest_distance < cfg.stop_mm) begin
      dec_next   = oasd_pkg::DEC_TOO_CLOSE;
      avoid_next = 1'b1;
      ticks_next = 10'd0;
    end else if (obstacle_present && !avoid_mode) begin
      dec_next   = oasd_pkg::DEC_AVOID_START;
      steer_next = 1'b1;
      avoid_next = 1'b1;
      ticks_next = 10'd0;
    end else if (avoid_mode) begin
      if (obstacle_present) begin
        dec_next   = oasd_pkg::DEC_AVOIDING;
        steer_next = 1'b1;
        ticks_next = 10'd0;
      end else if (ticks_inc >= cfg.clear_limit) begin
        dec_next   = oasd_pkg::DEC_CLEAR;
        avoid_next = 1'b0;
        ticks_next = 10'd0;
      end else begin
        dec_next   = oasd_pkg::DEC_AVOIDING;
        steer_next = 1'b1;
        ticks_next = ticks_inc;
      end
    end
  end

  // half servo span, signed when limits are inconsistent
  always_comb begin
    r1 = $signed({1'b0, cfg.srv_mid}) - $signed({1'b0, cfg.srv_lo});
    r2 = $signed({1'b0, cfg.srv_hi}) - $signed({1'b0, cfg.srv_mid});
    range_next = (r1 < r2) ? r1 : r2;
  end

  // -gain*angle / 256, rounded half away from zero, clamped to +-max
  always_comb begin
    p_neg = prod[35];
    p_mag = p_neg ? $unsigned(-prod) : $unsigned(prod);
    p_sum = p_mag + 36'd128;
    s_q   = p_sum[35:8];
    s_mag = (s_q > {13'd0, cfg.max_steering}) ? cfg.max_steering : s_q[14:0];
    steer = (p_neg ^ oasd_pkg::STEER_INVERT) ? $signed({1'b0, s_mag})
                                               : -$signed({1'b0, s_mag});
    if (!steer_en) steer = 16'sd0;
  end

  // center + steer*range / 32768, rounded, then clamped to servo limits
  always_comb begin
    v_neg   = prod[35];
    v_mag   = v_neg ? $unsigned(-prod) : $unsigned(prod);
    v_sum   = v_mag + 36'd16384;
    v_q     = v_sum[35:15];
    lo19    = $signed({3'b0, cfg.srv_lo});
    hi19    = $signed({3'b0, cfg.srv_hi});
    pos_raw = v_neg ? $signed({3'b0, cfg.srv_mid}) - $signed({1'b0, v_q[17:0]})
                    : $signed({3'b0, cfg.srv_mid}) + $signed({1'b0, v_q[17:0]});
    if (pos_raw < lo19)      pos = lo19;
    else if (pos_raw > hi19) pos = hi19;
    else                     pos = pos_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      avoid_mode  <= 1'b0;
      clear_ticks <= 10'd0;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_SERVO && out_free) out_valid <= 1'b1;
      else if (out_ready)               out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            avoid_mode  <= avoid_next;
            clear_ticks <= ticks_next;
            dec_r       <= dec_next;
            steer_en    <= steer_next;
            motor_r     <= steer_next ? cfg.avoid_motor_command : 16'd0;
            range_r     <= range_next;
            op_a        <= $signed({2'b0, cfg.steering_gain});
            op_b        <= {{2{gap_dir[15]}}, gap_dir};
            state       <= S_MUL1;
          end
        end
        S_MUL1: state <= S_STEER;
        S_STEER: begin
          op_a  <= {{2{steer[15]}}, steer};
          op_b  <= {range_r[16], range_r};
          state <= S_MUL2;
        end
        S_MUL2: state <= S_SERVO;
        S_SERVO: begin
          if (out_free) begin
            servo_position <= pos[15:0];
            motor_command  <= motor_r;
            decision       <= dec_r;
            avoiding_now   <= avoid_mode;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_clear_ticks_idle: assert property (@(posedge clk) disable iff (rst)
    !avoid_mode |-> clear_ticks == 10'd0)
    else $error("clear counter nonzero outside avoidance");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("ready right after a transfer");

  a_motor_only_steering: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_command != 16'd0 |->
      decision == oasd_pkg::DEC_AVOID_START || decision == oasd_pkg::DEC_AVOIDING)
    else $error("motor command without steering decision");

  a_mode_matches_decision: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (decision == oasd_pkg::DEC_CLEAR && !avoiding_now) ||
                  (decision != oasd_pkg::DEC_CLEAR && avoiding_now))
    else $error("avoidance flag disagrees with decision");
`endif

endmodule

// File: hw/rtl/obstacle_avoid_steer_decision_top.sv
// The sequencer runs gain*angle and then steer*range through one shared 18x18 multiplier,
// stepping from idle through S_MUL1, S_STEER, S_MUL2 and S_SERVO for each input transfer.
// A new tick is taken only in idle, so not before the last one has left S_SERVO, which
// waits while the output register still holds a result not yet taken.
// Reset (rst, synchronous, active high): registers to defaults, not avoiding,
// clear counter 0, no result pending.
`timescale 1ns / 1ps

module obstacle_avoid_steer_decision_top (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [oasd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,   // gap_dir[15:0], nearest_distance[31:16]
  input  logic                        s_axis_tuser,   // obstacle_present
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,   // servo_position[15:0], motor_command[31:16]
  output logic [2:0]                  m_axis_tuser    // decision[1:0], avoiding_now[2]
);

  oasd_pkg::cfg_t     cfg;
  logic signed [17:0] op_a, op_b;
  logic signed [35:0] prod;
  logic [15:0]        servo_position, motor_command;
  logic [1:0]         decision;
  logic               avoiding_now;

  oasd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  oasd_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  oasd_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .gap_dir          ($signed(s_axis_tdata[15:0])),
    .nearest_distance (s_axis_tdata[31:16]),
    .obstacle_present (s_axis_tuser),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .servo_position   (servo_position),
    .motor_command    (motor_command),
    .decision         (decision),
    .avoiding_now     (avoiding_now),
    .op_a             (op_a),
    .op_b             (op_b),
    .prod             (prod)
  );

  assign m_axis_tdata = {motor_command, servo_position};
  assign m_axis_tuser = {avoiding_now, decision};

endmodule

// File: dv/oasd_checker.sv
// Scoreboard for the obstacle-avoidance steering block: tracks APB writes, predicts
// each tick's result from the accepted input transfers and compares the result transfers.
// Depends on oasd_pkg for the register map, decision codes and cfg_t.
`timescale 1ns / 1ps

module oasd_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [oasd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,   // gap_dir[15:0], nearest_distance[31:16]
  input  logic                        s_axis_tuser,   // obstacle_present
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [31:0]                 m_axis_tdata,   // servo_position[15:0], motor_command[31:16]
  input  logic [2:0]                  m_axis_tuser,   // decision[1:0], avoiding_now[2]
  output int                          fail_count,
  output int                          open_ticks
);

  typedef struct packed {
    logic [15:0] servo;
    logic [15:0] motor;
    logic [1:0]  decision;
    logic        avoiding;
  } tick_result_t;

  oasd_pkg::cfg_t cfg;
  logic           avoid_mode;
  logic [9:0]     clear_ticks;
  tick_result_t   tick_results_q[$];
  int             fails = 0;
  int             pending = 0;

  assign fail_count = fails;
  assign open_ticks = pending;

  // v / 2^sh, nearest, halves away from zero
  function automatic longint round_half_away(longint v, int sh);
    longint m;
    longint q;
    m = (v < 0) ? -v : v;
    q = (m + (longint'(1) << (sh - 1))) >> sh;
    return (v < 0) ? -q : q;
  endfunction

  function automatic longint steer_to_gap(oasd_pkg::cfg_t c, logic signed [15:0] angle);
    longint s;
    longint lim;
    s = -round_half_away(longint'(c.steering_gain) * longint'(angle), 8);
    lim = longint'(c.max_steering);
    if (s < -lim) s = -lim;
    if (s > lim) s = lim;
    return s;
  endfunction

  function automatic logic [15:0] servo_map(oasd_pkg::cfg_t c, longint s);
    longint ctr;
    longint lo;
    longint hi;
    longint span;
    longint pos;
    ctr = longint'(c.srv_mid);
    lo = longint'(c.srv_lo);
    hi = longint'(c.srv_hi);
    span = (ctr - lo < hi - ctr) ? ctr - lo : hi - ctr;
    pos = ctr + round_half_away(s * span, 15);
    if (pos < lo) pos = lo;
    else if (pos > hi) pos = hi;
    return pos[15:0];
  endfunction

  task automatic decide_tick(input logic [15:0] angle_raw, input logic [15:0] dist_mm,
                             input logic obst, output tick_result_t r);
    longint      steer;
    logic [15:0] motor;
    logic [1:0]  dec;
    steer = 0;
    motor = '0;
    if (dist_mm < cfg.stop_mm) begin
      dec = oasd_pkg::DEC_TOO_CLOSE;
      avoid_mode = 1'b1;
      clear_ticks = '0;
    end else if (obst && !avoid_mode) begin
      dec = oasd_pkg::DEC_AVOID_START;
      steer = steer_to_gap(cfg, angle_raw);
      motor = cfg.avoid_motor_command;
      avoid_mode = 1'b1;
      clear_ticks = '0;
    end else if (avoid_mode) begin
      // only obstacle-free ticks count toward the exit
      if (obst) clear_ticks = '0;
      else clear_ticks = clear_ticks + 10'd1;
      if (!obst && clear_ticks >= cfg.clear_limit) begin
        dec = oasd_pkg::DEC_CLEAR;
        avoid_mode = 1'b0;
        clear_ticks = '0;
      end else begin
        dec = oasd_pkg::DEC_AVOIDING;
        steer = steer_to_gap(cfg, angle_raw);
        motor = cfg.avoid_motor_command;
      end
    end else begin
      dec = oasd_pkg::DEC_CLEAR;
    end
    if (oasd_pkg::STEER_INVERT) steer = -steer;
    r.servo = servo_map(cfg, steer);
    r.motor = motor;
    r.decision = dec;
    r.avoiding = avoid_mode;
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    tick_result_t got;
    if (rst) begin
      cfg.stop_mm = 16'd200;
      cfg.steering_gain = 16'd1678;
      cfg.max_steering = 15'd16384;
      cfg.clear_limit = 10'd20;
      cfg.srv_mid = 16'd37356;
      cfg.srv_lo = 16'd0;
      cfg.srv_hi = 16'd65535;
      cfg.avoid_motor_command = 16'd60;
      avoid_mode = 1'b0;
      clear_ticks = '0;
      tick_results_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[oasd_pkg::ADDR_W-1:2])
          oasd_pkg::REG_STOP_MM:       cfg.stop_mm = pwdata[15:0];
          oasd_pkg::REG_STEERING_GAIN: cfg.steering_gain = pwdata[15:0];
          oasd_pkg::REG_MAX_STEERING:  cfg.max_steering = pwdata[14:0];
          oasd_pkg::REG_CLEAR_LIMIT:   cfg.clear_limit = pwdata[9:0];
          oasd_pkg::REG_SRV_MID:       cfg.srv_mid = pwdata[15:0];
          oasd_pkg::REG_SRV_LO:        cfg.srv_lo = pwdata[15:0];
          oasd_pkg::REG_SRV_HI:        cfg.srv_hi = pwdata[15:0];
          oasd_pkg::REG_AVOID_MOTOR:   cfg.avoid_motor_command = pwdata[15:0];
          default: ;
        endcase
      end
      // results come first: a result never belongs to a tick taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser[1:0], m_axis_tuser[2]};
        if (tick_results_q.size() == 0) begin
          $display("%0t: result with no tick pending: expected none, actual %h", $time, got);
          fails++;
        end else begin
          want = tick_results_q.pop_front();
          if (got.servo !== want.servo) begin
            $display("%0t: servo_position expected %0d actual %0d", $time, want.servo,
                     got.servo);
            fails++;
          end
          if (got.motor !== want.motor) begin
            $display("%0t: motor_command expected %0d actual %0d", $time, want.motor,
                     got.motor);
            fails++;
          end
          if (got.decision !== want.decision) begin
            $display("%0t: decision expected %0d actual %0d", $time, want.decision,
                     got.decision);
            fails++;
          end
          if (got.avoiding !== want.avoiding) begin
            $display("%0t: avoiding_now expected %0b actual %0b", $time, want.avoiding,
                     got.avoiding);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decide_tick(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tuser, want);
        tick_results_q.push_back(want);
      end
    end
    pending = tick_results_q.size();
  end

endmodule

// File: dv/tb.sv
// Testbench top for obstacle_avoid_steer_decision_top: clock, reset, APB setup,
// tick stimulus with bursty sender and stalling receiver, and the verdict.
// Depends on oasd_pkg, the block and oasd_checker.
`timescale 1ns / 1ps

module tb;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [oasd_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [31:0]                 s_axis_tdata = '0;
  logic                        s_axis_tuser = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [31:0]                 m_axis_tdata;
  logic [2:0]                  m_axis_tuser;
  int                          fail_count;
  int                          open_ticks;

  oasd_pkg::cfg_t cur_cfg;
  int             burst_left = 0;
  logic           run_obst = 1'b0;
  int             run_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  obstacle_avoid_steer_decision_top u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  oasd_checker u_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .fail_count(fail_count), .open_ticks(open_ticks)
  );

  // receiver: duty pattern over a short period, re-rolled every so often
  int rx_period = 1;
  int rx_duty = 1;
  int rx_phase = 0;
  int rx_hold = 0;
  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_hold = $urandom_range(20, 150);
      rx_period = $urandom_range(1, 16);
      rx_duty = ($urandom_range(0, 3) == 0) ? rx_period : $urandom_range(0, rx_period);
    end
    rx_hold--;
    m_axis_tready = (rx_phase % rx_period) < rx_duty;
    rx_phase++;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic write_cfg(input oasd_pkg::cfg_t c);
    write_reg(oasd_pkg::REG_STOP_MM, 32'(c.stop_mm));
    write_reg(oasd_pkg::REG_STEERING_GAIN, 32'(c.steering_gain));
    write_reg(oasd_pkg::REG_MAX_STEERING, 32'(c.max_steering));
    write_reg(oasd_pkg::REG_CLEAR_LIMIT, 32'(c.clear_limit));
    write_reg(oasd_pkg::REG_SRV_MID, 32'(c.srv_mid));
    write_reg(oasd_pkg::REG_SRV_LO, 32'(c.srv_lo));
    write_reg(oasd_pkg::REG_SRV_HI, 32'(c.srv_hi));
    write_reg(oasd_pkg::REG_AVOID_MOTOR, 32'(c.avoid_motor_command));
    cur_cfg = c;
  endtask

  // one tick transfer; a new burst starts with a random gap
  task automatic send_tick(input logic [15:0] angle, input logic [15:0] dist_mm,
                           input logic obst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {dist_mm, angle};
    s_axis_tuser = obst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // drain: stop sending, wait for every result, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (open_ticks != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // obstacle runs alternate with obstacle-free runs sized around the threshold
  task automatic random_tick();
    logic [15:0] angle;
    logic [15:0] dist_mm;
    logic        obst;
    int          thr;
    int          stop;
    int          pick;
    thr = cur_cfg.clear_limit;
    stop = cur_cfg.stop_mm;
    while (run_left == 0) begin
      run_obst = !run_obst;
      if (run_obst) run_left = $urandom_range(1, 6);
      else if (thr <= 40) run_left = $urandom_range(0, thr + 2);
      else run_left = $urandom_range(0, 30);
    end
    run_left--;
    obst = ($urandom_range(0, 11) == 0) ? !run_obst : run_obst;
    pick = $urandom_range(0, 9);
    if (pick == 0) angle = 16'($urandom);
    else if (pick == 1) begin
      case ($urandom_range(0, 4))
        0: angle = 16'(18000);
        1: angle = 16'(-18000);
        2: angle = 16'(64);
        3: angle = 16'(-64);
        default: angle = 16'($urandom_range(0, 4) - 2);
      endcase
    end else angle = 16'($urandom_range(0, 36000) - 18000);
    pick = $urandom_range(0, 11);
    if (pick == 0 && stop > 0) dist_mm = 16'($urandom_range(0, stop - 1));
    else if (pick == 1) dist_mm = 16'(stop - $urandom_range(0, 1));
    else if (pick == 2) dist_mm = 16'($urandom);
    else dist_mm = 16'($urandom_range(stop, 65535));
    send_tick(angle, dist_mm, obst);
  endtask

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    oasd_pkg::cfg_t c;
    cur_cfg.stop_mm = 16'd200;
    cur_cfg.steering_gain = 16'd1678;
    cur_cfg.max_steering = 15'd16384;
    cur_cfg.clear_limit = 10'd20;
    cur_cfg.srv_mid = 16'd37356;
    cur_cfg.srv_lo = 16'd0;
    cur_cfg.srv_hi = 16'd65535;
    cur_cfg.avoid_motor_command = 16'd60;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed, reset settings: stop boundary, clamps, rounding halves
    send_tick(16'd0, 16'd0, 1'b0);
    send_tick(16'(18000), 16'd199, 1'b1);
    send_tick(16'(-18000), 16'd200, 1'b1);
    send_tick(16'(18000), 16'd65535, 1'b1);
    send_tick(16'h8000, 16'd65535, 1'b1);
    send_tick(16'h7fff, 16'd300, 1'b1);
    send_tick(16'(64), 16'd300, 1'b1);
    send_tick(16'(-64), 16'd300, 1'b0);
    drain();
    // clear exit after a short threshold, too close restarts the count
    write_reg(oasd_pkg::REG_CLEAR_LIMIT, 32'd3);
    cur_cfg.clear_limit = 10'd3;
    send_tick(16'(-1), 16'd500, 1'b0);
    send_tick(16'(2), 16'd500, 1'b0);
    send_tick(16'(100), 16'd500, 1'b0);
    send_tick(16'(-100), 16'd500, 1'b1);
    send_tick(16'(0), 16'd500, 1'b0);
    send_tick(16'(0), 16'd100, 1'b0);
    send_tick(16'(5), 16'd500, 1'b0);
    send_tick(16'(5), 16'd500, 1'b0);
    send_tick(16'(5), 16'd500, 1'b0);
    drain();
    // zero threshold: first obstacle-free tick ends avoidance
    write_reg(oasd_pkg::REG_CLEAR_LIMIT, 32'd0);
    cur_cfg.clear_limit = 10'd0;
    send_tick(16'(50), 16'd500, 1'b1);
    send_tick(16'(50), 16'd500, 1'b0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: c = '{16'd0, 16'd65535, 15'd32767, 10'd0, 16'd32768, 16'd0, 16'd65535, 16'd65535};
        1: c = '{16'd65535, 16'd0, 15'd0, 10'd1023, 16'd0, 16'd0, 16'd65535, 16'd0};
        // min above max, center outside the limits
        2: c = '{16'd1000, 16'd300, 15'd20000, 10'd5, 16'd60000, 16'd50000, 16'd10000,
                 16'd1234};
        3: c = '{16'd50, 16'd5000, 15'd32767, 10'd1, 16'd100, 16'd2000, 16'd65535, 16'd7};
        6: begin
          c.stop_mm = 16'($urandom);
          c.steering_gain = 16'($urandom);
          c.max_steering = 15'($urandom);
          c.clear_limit = 10'($urandom_range(0, 12));
          c.srv_mid = 16'($urandom);
          c.srv_lo = 16'($urandom);
          c.srv_hi = 16'($urandom);
          c.avoid_motor_command = 16'($urandom);
        end
        default: begin
          c.stop_mm = 16'($urandom_range(0, 3000));
          c.steering_gain = 16'($urandom);
          c.max_steering = 15'($urandom);
          c.clear_limit = 10'($urandom_range(0, 30));
          c.srv_mid = 16'($urandom);
          c.srv_lo = 16'($urandom_range(0, c.srv_mid));
          c.srv_hi = 16'($urandom_range(c.srv_mid, 65535));
          c.avoid_motor_command = 16'($urandom);
        end
      endcase
      write_cfg(c);
      run_left = 0;
      repeat (190) random_tick();
      drain();
    end

    if (fail_count == 0 && open_ticks == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/oasd_pkg.sv
hw/rtl/oasd_cfg.sv
hw/rtl/oasd_mul.sv
hw/rtl/oasd_seq.sv
hw/rtl/obstacle_avoid_steer_decision_top.sv
dv/oasd_checker.sv
dv/tb.sv
